[rtl/assert_macros.svh]
// Assertion macros for the page frame allocator.
// Needs a clock named clk and a reset named rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, switched off during reset.
`define PFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression that must never be true outside reset.
`define PFA_NEVER(lbl, expr, msg) \
  `PFA_ASSERT(lbl, !(expr), msg)

`endif

[rtl/pfa_pkg.sv]
// Package for the page frame free list allocator: sizes, codes, item types.
// No dependencies.
`default_nettype none

package pfa_pkg;

  localparam int PAGE_COUNT = 4096;
  localparam int PAGE_W     = 12;
  localparam int LINK_W     = 13;
  localparam int COUNT_W    = 13;
  localparam int CFG_IDX_W  = 2;

  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(PAGE_COUNT);

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_ALLOC = 2'd2,
    CMD_FREE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL_FIRST = 2'd0,
    REG_KERNEL_LAST  = 2'd1
  } reg_idx_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [PAGE_W-1:0]   region_first_page;
    logic [COUNT_W-1:0]  region_page_count;
    logic                region_available;
    logic [PAGE_W-1:0]   freed_page;
    logic                freed_valid;
  } cmd_item_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page_number;
    status_t           status;
  } result_item_t;

endpackage

`default_nettype wire

[rtl/page_frame_free_list_allocator.sv]
// Page frame free list allocator: LIFO list of frames in a next-link RAM.
// Depends on pfa_pkg and assert_macros.svh.
// Clear, free, ignored and empty-list allocate commands give their result in the
// cycle after acceptance; allocate passes through S_ALLOC when the list holds a page
// (one RAM read plus the head update), and add region with a non-empty region through
// S_ADD, one page pushed per cycle, set by the single write port of the link RAM. Each item yields one result,
// shown for one cycle on result with result_valid; it cannot be held off, so
// take it when it appears. busy is high while the allocator is in S_ADD or S_ALLOC.
// Configuration writes are always accepted; only indexes 0 and 1 have effect.
`default_nettype none
`include "assert_macros.svh"

module page_frame_free_list_allocator (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire pfa_pkg::cmd_item_t            item,
  output logic                               result_valid,
  output pfa_pkg::result_item_t              result,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [pfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pfa_pkg::PAGE_W-1:0]    cfg_data
);
  import pfa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ADD   = 3'b010,
    S_ALLOC = 3'b100
  } state_t;

  state_t             state;
  logic [LINK_W-1:0]  head;
  logic [PAGE_W-1:0]  kernel_first_page;
  logic [PAGE_W-1:0]  kernel_last_page;
  logic [LINK_W-1:0]  cur;
  logic [LINK_W-1:0]  end_page;

  logic [LINK_W-1:0]  next_link [PAGE_COUNT];
  logic               mem_we;
  logic [PAGE_W-1:0]  mem_waddr;
  logic [LINK_W-1:0]  rd_data;
  logic               rd_en;

  logic               accept;
  logic               head_empty;
  logic               in_kernel;
  logic               add_ok;
  logic               free_ok;
  logic [LINK_W:0]    region_sum;
  logic [LINK_W-1:0]  region_end;
  logic [LINK_W-1:0]  cur_inc;
  logic               empty_alloc;
  logic               empty_reply;

  assign busy       = (state != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign accept     = start && !busy;
  assign head_empty = (head >= LINK_NULL);
  assign in_kernel  = (item.region_first_page >= kernel_first_page) &&
                      (item.region_first_page <= kernel_last_page);
  assign add_ok     = item.region_available && !in_kernel;
  assign free_ok    = item.freed_valid && ({1'b0, item.freed_page} < LINK_NULL);
  assign region_sum = {2'b00, item.region_first_page} + {1'b0, item.region_page_count};
  assign region_end = (region_sum > {1'b0, LINK_NULL}) ? LINK_NULL
                                                       : region_sum[LINK_W-1:0];
  assign cur_inc    = cur + LINK_W'(1);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur[PAGE_W-1:0];
    if (state == S_ADD) begin
      mem_we = 1'b1;
    end else if (accept && item.cmd == CMD_FREE && free_ok) begin
      mem_we    = 1'b1;
      mem_waddr = item.freed_page;
    end
  end

  assign rd_en = accept && (item.cmd == CMD_ALLOC) && !head_empty;

  // link RAM: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      next_link[mem_waddr] <= head;
    end
    if (rd_en) begin
      rd_data <= next_link[head[PAGE_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_first_page <= '0;
      kernel_last_page  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_KERNEL_FIRST) begin
        kernel_first_page <= cfg_data;
      end else if (cfg_index == REG_KERNEL_LAST) begin
        kernel_last_page <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head         <= LINK_NULL;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (item.cmd)
              CMD_CLEAR: begin
                head         <= LINK_NULL;
                result_valid <= 1'b1;
              end
              CMD_ADD: begin
                if (add_ok && ({1'b0, item.region_first_page} < region_end)) begin
                  state <= S_ADD;
                end else begin
                  result_valid <= 1'b1;
                end
              end
              CMD_ALLOC: begin
                if (head_empty) begin
                  result_valid <= 1'b1;
                end else begin
                  state <= S_ALLOC;
                end
              end
              CMD_FREE: begin
                if (free_ok) begin
                  head <= {1'b0, item.freed_page};
                end
                result_valid <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        S_ADD: begin
          head <= cur;
          if (cur_inc == end_page) begin
            state        <= S_IDLE;
            result_valid <= 1'b1;
          end
        end
        S_ALLOC: begin
          head         <= (rd_data > LINK_NULL) ? LINK_NULL : rd_data;
          state        <= S_IDLE;
          result_valid <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cur                <= {1'b0, item.region_first_page};
          end_page           <= region_end;
          result.page_number <= '0;
          unique case (item.cmd)
            CMD_CLEAR: result.status <= ST_DONE;
            CMD_ADD:   result.status <= add_ok ? ST_DONE : ST_IGNORED;
            CMD_ALLOC: result.status <= head_empty ? ST_EMPTY : ST_DONE;
            CMD_FREE:  result.status <= free_ok ? ST_DONE : ST_IGNORED;
            default:   result.status <= ST_DONE;
          endcase
        end
      end
      S_ADD: begin
        cur <= cur_inc;
      end
      S_ALLOC: begin
        result.page_number <= head[PAGE_W-1:0];
      end
      default: ;
    endcase
  end

  assign empty_alloc = accept && (item.cmd == CMD_ALLOC) && head_empty;
  assign empty_reply = result_valid && (result.status == ST_EMPTY);

  `PFA_ASSERT(a_empty_alloc, empty_alloc |=> empty_reply, "allocate on empty list not reported")
  `PFA_ASSERT(a_alloc_result, state == S_ALLOC |=> result_valid && !busy, "no allocate result")
  `PFA_NEVER(a_head_range, head > LINK_NULL, "list head out of range")
  `PFA_NEVER(a_rw_overlap, mem_we && state == S_ALLOC, "link write during allocate")

endmodule

`default_nettype wire

[dv/frame_list_checker.sv]
`timescale 1ns / 1ps
// Checker for the page frame free list allocator: tracks the free list and
// kernel range, predicts each reply and compares it. Needs pfa_pkg.
module frame_list_checker
  import pfa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  cmd_item_t            item,
  input  logic                 result_valid,
  input  result_item_t         result,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PAGE_W-1:0]    cfg_data,
  output int unsigned          outstanding,
  output int unsigned          fail_count
);

  logic [LINK_W-1:0] frame_link [PAGE_COUNT];
  logic [LINK_W-1:0] head_frame;
  logic [PAGE_W-1:0] kernel_lo;
  logic [PAGE_W-1:0] kernel_hi;
  result_item_t      awaited_replies [$];
  result_item_t      oldest;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic result_item_t run_list_command(input cmd_item_t c);
    result_item_t      r;
    int unsigned       stop;
    int unsigned       p;
    logic [LINK_W-1:0] nxt;
    r.page_number = '0;
    r.status      = ST_DONE;
    case (c.cmd)
      CMD_CLEAR: head_frame = LINK_NULL;
      CMD_ADD: begin
        if (!c.region_available ||
            (c.region_first_page >= kernel_lo && c.region_first_page <= kernel_hi)) begin
          r.status = ST_IGNORED;
        end else begin
          stop = int'(c.region_first_page) + int'(c.region_page_count);
          if (stop > PAGE_COUNT) stop = PAGE_COUNT;
          for (p = c.region_first_page; p < stop; p++) begin
            frame_link[p] = head_frame;
            head_frame    = LINK_W'(p);
          end
        end
      end
      CMD_ALLOC: begin
        if (head_frame >= PAGE_COUNT) begin
          r.status = ST_EMPTY;
        end else begin
          nxt           = frame_link[head_frame];
          r.page_number = head_frame[PAGE_W-1:0];
          head_frame    = (nxt > PAGE_COUNT) ? LINK_NULL : nxt;
        end
      end
      default: begin
        if (!c.freed_valid || c.freed_page >= PAGE_COUNT) begin
          r.status = ST_IGNORED;
        end else begin
          frame_link[c.freed_page] = head_frame;
          head_frame               = LINK_W'(c.freed_page);
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      awaited_replies.delete();
      head_frame  = LINK_NULL;
      kernel_lo   = '0;
      kernel_hi   = '0;
      outstanding = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_KERNEL_FIRST: kernel_lo = cfg_data;
          REG_KERNEL_LAST:  kernel_hi = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) awaited_replies.push_back(run_list_command(item));
      if (result_valid) begin
        if (awaited_replies.size() == 0) begin
          report_mismatch("unexpected reply, count", 1, 0);
        end else begin
          oldest = awaited_replies.pop_front();
          if (result.page_number !== oldest.page_number)
            report_mismatch("page_number", int'(result.page_number), int'(oldest.page_number));
          if (result.status !== oldest.status)
            report_mismatch("status", int'(result.status), int'(oldest.status));
        end
      end
      outstanding = awaited_replies.size();
    end
  end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Top of the page frame allocator bench: clock, reset, command and register
// stimulus, verdict. Needs pfa_pkg, the allocator and frame_list_checker.
module tb_top;
  import pfa_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 108;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  cmd_item_t            item;
  logic                 result_valid;
  result_item_t         result;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PAGE_W-1:0]    cfg_data;
  int unsigned          outstanding;
  int unsigned          fail_count;

  page_frame_free_list_allocator u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  frame_list_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .outstanding  (outstanding),
    .fail_count   (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic cmd_item_t make_item(input cmd_t c, input int first, input int count,
                                          input bit avail, input int fpage, input bit fvalid);
    cmd_item_t it;
    it.cmd               = c;
    it.region_first_page = PAGE_W'(first);
    it.region_page_count = COUNT_W'(count);
    it.region_available  = avail;
    it.freed_page        = PAGE_W'(fpage);
    it.freed_valid       = fvalid;
    return it;
  endfunction

  function automatic cmd_item_t random_item();
    cmd_item_t   it;
    int unsigned pick;
    int unsigned size;
    it.cmd               = CMD_CLEAR;
    it.region_first_page = PAGE_W'($urandom);
    it.region_page_count = COUNT_W'($urandom_range(0, PAGE_COUNT));
    it.region_available  = 1'($urandom);
    it.freed_page        = PAGE_W'($urandom);
    it.freed_valid       = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      it.cmd = CMD_CLEAR;
    end else if (pick < 30) begin
      it.cmd = CMD_ADD;
      it.region_available = ($urandom_range(0, 99) < 80);
      size = $urandom_range(0, 99);
      // big counts mostly near the top of the store, where clipping keeps them cheap
      if (size < 85) it.region_page_count = COUNT_W'($urandom_range(0, 24));
      else if (size < 97) it.region_first_page = PAGE_W'($urandom_range(3584, PAGE_COUNT - 1));
    end else if (pick < 70) begin
      it.cmd = CMD_ALLOC;
    end else begin
      it.cmd = CMD_FREE;
      it.freed_valid = ($urandom_range(0, 99) < 85);
    end
    return it;
  endfunction

  task automatic drive_item(input cmd_item_t it, input int idle_pct);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct && gap < 30) begin
      @(negedge clk);
      start = 1'b0;
      gap++;
    end
    @(negedge clk);
    start = 1'b1;
    item  = it;
    do @(posedge clk); while (busy);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAGE_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_kernel(input logic [PAGE_W-1:0] lo, input logic [PAGE_W-1:0] hi);
    write_reg(REG_KERNEL_FIRST, lo);
    write_reg(REG_KERNEL_LAST, hi);
    write_reg(REG_SPARE_2, PAGE_W'($urandom));
    write_reg(REG_SPARE_3, PAGE_W'($urandom));
  endtask

  cmd_item_t         directed [$];
  logic [PAGE_W-1:0] kernel_lo_set [PHASES];
  logic [PAGE_W-1:0] kernel_hi_set [PHASES];
  int                idle_set [PHASES];

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    item      = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_KERNEL_FIRST;
    cfg_data  = '0;
    kernel_lo_set = '{12'd4095, 12'd0, 12'd1000, 12'd1024, 12'd0, 12'd3000};
    kernel_hi_set = '{12'd4095, 12'd4095, 12'd500, 12'd2047, 12'd0, 12'd3100};
    idle_set      = '{36, 36, 77, 77, 0, 0};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    set_kernel(12'd0, 12'd0);
    directed.push_back(make_item(CMD_ALLOC, 0, 0, 1'b0, 0, 1'b0));
    directed.push_back(make_item(CMD_CLEAR, 4095, 4096, 1'b1, 4095, 1'b1));
    directed.push_back(make_item(CMD_FREE, 0, 0, 1'b0, 5, 1'b0));
    directed.push_back(make_item(CMD_FREE, 0, 0, 1'b0, 4095, 1'b1));
    directed.push_back(make_item(CMD_FREE, 0, 0, 1'b0, 0, 1'b1));
    directed.push_back(make_item(CMD_ALLOC, 0, 0, 1'b0, 0, 1'b0));
    directed.push_back(make_item(CMD_ALLOC, 0, 0, 1'b0, 0, 1'b0));
    directed.push_back(make_item(CMD_ALLOC, 0, 0, 1'b0, 0, 1'b0));
    directed.push_back(make_item(CMD_ADD, 10, 3, 1'b0, 0, 1'b0));
    directed.push_back(make_item(CMD_ADD, 0, 5, 1'b1, 0, 1'b0));
    directed.push_back(make_item(CMD_ADD, 20, 0, 1'b1, 0, 1'b0));
    directed.push_back(make_item(CMD_ADD, 4090, 4096, 1'b1, 0, 1'b0));
    directed.push_back(make_item(CMD_ALLOC, 0, 0, 1'b0, 0, 1'b0));
    directed.push_back(make_item(CMD_ADD, 1, 4096, 1'b1, 0, 1'b0));
    directed.push_back(make_item(CMD_CLEAR, 0, 0, 1'b0, 0, 1'b0));
    directed.push_back(make_item(CMD_ADD, 4095, 1, 1'b1, 0, 1'b0));
    directed.push_back(make_item(CMD_ALLOC, 0, 0, 1'b0, 0, 1'b0));
    // double free of one page makes the list loop on itself
    directed.push_back(make_item(CMD_FREE, 0, 0, 1'b0, 7, 1'b1));
    directed.push_back(make_item(CMD_FREE, 0, 0, 1'b0, 7, 1'b1));
    directed.push_back(make_item(CMD_ALLOC, 0, 0, 1'b0, 0, 1'b0));
    directed.push_back(make_item(CMD_ALLOC, 0, 0, 1'b0, 0, 1'b0));
    directed.push_back(make_item(CMD_CLEAR, 0, 0, 1'b0, 0, 1'b0));
    directed.push_back(make_item(CMD_ALLOC, 0, 0, 1'b0, 0, 1'b0));
    directed.push_back(make_item(CMD_ADD, 100, 3, 1'b1, 0, 1'b0));
    directed.push_back(make_item(CMD_ALLOC, 0, 0, 1'b0, 0, 1'b0));
    foreach (directed[i]) drive_item(directed[i], 36);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      set_kernel(kernel_lo_set[ph], kernel_hi_set[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        drive_item(random_item(), idle_set[ph]);
        if ($urandom_range(0, 49) == 0) drain();
      end
      drain();
    end

    repeat (20) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
